// ----- design/blum_blum_shub_generator_assert.svh -----
// Assertion macros for the generator's sequencer checks.
`ifndef BLUM_BLUM_SHUB_GENERATOR_ASSERT_SVH
`define BLUM_BLUM_SHUB_GENERATOR_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define BBS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define BBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bbs_pkg.sv -----
// Shared types and codes of the Blum Blum Shub generator.
package bbs_pkg;

  localparam int unsigned VAL_W    = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Request types
  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_GEN  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_MOD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_SEED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_P = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_Q = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODMUL,
    ST_MODCHK,
    ST_GCD,
    ST_REDUCE,
    ST_DBL,
    ST_ADD,
    ST_RESP
  } state_e;

endpackage

// ----- design/bbs_ifs.sv -----
// Handshake channels of the generator: request, response and configuration.
interface bbs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [bbs_pkg::VAL_W-1:0] seed_value;
  modport source (output valid, req_type, seed_value, input ready);
  modport sink (input valid, req_type, seed_value, output ready);
endinterface

interface bbs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bbs_pkg::VAL_W-1:0]    value;
  logic [bbs_pkg::STATUS_W-1:0] status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

interface bbs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bbs_pkg::CFG_IDX_W-1:0] index;
  logic [bbs_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/blum_blum_shub_generator.sv -----
// Blum Blum Shub generator: shared 65-bit subtract/compare unit under a small sequencer.
// Generate beat: a bit-serial reduction of the state by the modulus, then a double-and-add
// square in ST_DBL/ST_ADD; the result passes through ST_RESP to the output register.
// Seed beat: ST_MODMUL, ST_MODCHK, then one binary-gcd step per cycle in ST_GCD, advancing
// the candidate on a common factor. One request at a time; the output register lets the
// next request start meanwhile. Reset (rst_ni low, async) clears primes, modulus, state,
// seeded flag and output valid flag.
`include "blum_blum_shub_generator_assert.svh"

module blum_blum_shub_generator #(
  parameter int unsigned PRIME_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbs_cfg_if.sink   cfg_i,
  bbs_req_if.sink   req_i,
  bbs_rsp_if.source rsp_o
);

  localparam int unsigned VW = bbs_pkg::VAL_W;

  bbs_pkg::state_e state_q, state_d;

  logic [PRIME_BITS-1:0]   p_q, q_q;
  logic [2*PRIME_BITS-1:0] prod;
  logic [VW-1:0]           mod_q, mod_d;
  logic [VW-1:0]           cur_q, cur_d;
  logic                    seeded_q, seeded_d;
  logic [VW-1:0]           x_q, x_d;
  logic [VW-1:0]           a_q, a_d;
  logic [VW-1:0]           b_q, b_d;
  logic [5:0]              cnt_q, cnt_d;
  logic [VW-1:0]           res_val_q, res_val_d;
  logic [bbs_pkg::STATUS_W-1:0] res_st_q, res_st_d;
  logic                    out_valid_q, out_valid_d;
  logic [VW-1:0]           out_val_q, out_val_d;
  logic [bbs_pkg::STATUS_W-1:0] out_st_q, out_st_d;

  // Shared unit operands and outputs
  logic [VW:0]   unit_u, unit_v;
  logic [VW+1:0] unit_diff;
  logic          unit_ge;
  logic [VW-1:0] unit_sel;
  logic [VW-1:0] x_inc;

  logic req_fire;
  logic cfg_fire;

  assign req_fire = req_i.valid && req_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.value  = out_val_q;
  assign rsp_o.status = out_st_q;

  // Modulus product, registered in its own state
  assign prod  = p_q * q_q;
  assign x_inc = x_q + 64'd1;

  // Select operands of the shared subtract/compare unit
  always_comb begin
    case (state_q)
      bbs_pkg::ST_GCD: begin
        unit_u = {1'b0, a_q};
        unit_v = {1'b0, b_q};
      end
      bbs_pkg::ST_REDUCE: begin
        unit_u = {b_q, x_q[cnt_q]};
        unit_v = {1'b0, mod_q};
      end
      bbs_pkg::ST_DBL: begin
        unit_u = {b_q, 1'b0};
        unit_v = {1'b0, mod_q};
      end
      bbs_pkg::ST_ADD: begin
        unit_u = {1'b0, b_q} + {1'b0, a_q};
        unit_v = {1'b0, mod_q};
      end
      default: begin
        unit_u = '0;
        unit_v = '0;
      end
    endcase
  end

  assign unit_diff = {1'b0, unit_u} - {1'b0, unit_v};
  assign unit_ge   = ~unit_diff[VW+1];
  assign unit_sel  = unit_ge ? unit_diff[VW-1:0] : unit_u[VW-1:0];

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    mod_d       = mod_q;
    cur_d       = cur_q;
    seeded_d    = seeded_q;
    x_d         = x_q;
    a_d         = a_q;
    b_d         = b_q;
    cnt_d       = cnt_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    req_i.ready = (state_q == bbs_pkg::ST_IDLE);

    // Drop the output beat once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bbs_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req_i.req_type == bbs_pkg::REQ_SEED) begin
            x_d     = req_i.seed_value;
            state_d = bbs_pkg::ST_MODMUL;
          end else if (!seeded_q) begin
            res_val_d = '0;
            res_st_d  = bbs_pkg::STATUS_NO_SEED;
            state_d   = bbs_pkg::ST_RESP;
          end else begin
            x_d     = cur_q;
            b_d     = '0;
            cnt_d   = 6'd63;
            state_d = bbs_pkg::ST_REDUCE;
          end
        end
      end

      bbs_pkg::ST_MODMUL: begin
        mod_d   = VW'(prod);
        state_d = bbs_pkg::ST_MODCHK;
      end

      bbs_pkg::ST_MODCHK: begin
        if (mod_q < 64'd3) begin
          seeded_d  = 1'b0;
          cur_d     = '0;
          res_val_d = '0;
          res_st_d  = bbs_pkg::STATUS_BAD_MOD;
          state_d   = bbs_pkg::ST_RESP;
        end else begin
          a_d     = x_q;
          b_d     = mod_q;
          state_d = bbs_pkg::ST_GCD;
        end
      end

      // One binary-gcd step; only coprimality matters
      bbs_pkg::ST_GCD: begin
        if (a_q == 64'd1 || b_q == 64'd1) begin
          cur_d     = x_q;
          seeded_d  = 1'b1;
          res_val_d = x_q;
          res_st_d  = bbs_pkg::STATUS_OK;
          state_d   = bbs_pkg::ST_RESP;
        end else if (a_q == '0 || (!a_q[0] && !b_q[0]) ||
                     (a_q[0] && b_q[0] && unit_diff == '0)) begin
          // common factor found: advance the candidate and restart
          x_d = x_inc;
          a_d = x_inc;
          b_d = mod_q;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (unit_ge) begin
          a_d = unit_diff[VW-1:0];
        end else begin
          a_d = b_q;
          b_d = a_q;
        end
      end

      // Restoring reduction of x by the modulus, one bit per cycle
      bbs_pkg::ST_REDUCE: begin
        if (cnt_q == 6'd0) begin
          a_d     = unit_sel;
          b_d     = '0;
          cnt_d   = 6'd63;
          state_d = bbs_pkg::ST_DBL;
        end else begin
          b_d   = unit_sel;
          cnt_d = cnt_q - 6'd1;
        end
      end

      // Double-and-add square, top bit first
      bbs_pkg::ST_DBL: begin
        b_d = unit_sel;
        if (a_q[cnt_q]) begin
          state_d = bbs_pkg::ST_ADD;
        end else if (cnt_q == 6'd0) begin
          cur_d     = unit_sel;
          res_val_d = unit_sel;
          res_st_d  = bbs_pkg::STATUS_OK;
          state_d   = bbs_pkg::ST_RESP;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end

      bbs_pkg::ST_ADD: begin
        b_d = unit_sel;
        if (cnt_q == 6'd0) begin
          cur_d     = unit_sel;
          res_val_d = unit_sel;
          res_st_d  = bbs_pkg::STATUS_OK;
          state_d   = bbs_pkg::ST_RESP;
        end else begin
          cnt_d   = cnt_q - 6'd1;
          state_d = bbs_pkg::ST_DBL;
        end
      end

      // Hand the result to the output register when it is free
      bbs_pkg::ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = bbs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbs_pkg::ST_IDLE;
      p_q         <= '0;
      q_q         <= '0;
      mod_q       <= '0;
      cur_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mod_q       <= mod_d;
      cur_q       <= cur_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        if (cfg_i.index == bbs_pkg::CFG_PRIME_P) begin
          p_q <= cfg_i.data[PRIME_BITS-1:0];
        end else if (cfg_i.index == bbs_pkg::CFG_PRIME_Q) begin
          q_q <= cfg_i.data[PRIME_BITS-1:0];
        end
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    a_q       <= a_d;
    b_q       <= b_d;
    cnt_q     <= cnt_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  // Checks
  `BBS_ASSERT_NOW(a_seeded_mod, clk_i, rst_ni,
                  seeded_q && state_q != bbs_pkg::ST_MODCHK, mod_q >= 64'd3,
                  "seeded with modulus below 3")
  `BBS_ASSERT_NOW(a_residues, clk_i, rst_ni,
                  state_q == bbs_pkg::ST_DBL || state_q == bbs_pkg::ST_ADD,
                  a_q < mod_q && b_q < mod_q, "square operands not reduced")
  `BBS_ASSERT_NOW(a_gcd_nonzero, clk_i, rst_ni, state_q == bbs_pkg::ST_GCD, b_q != '0,
                  "gcd operand b is zero")
  `BBS_ASSERT_NEXT(a_req_busy, clk_i, rst_ni, req_fire, state_q != bbs_pkg::ST_IDLE,
                   "accepted request left sequencer idle")

endmodule
